### rtl/core/msmn_pkg.sv
// shared types and constants for the masked shift-min normalizer
package msmn_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ROW_COUNT       = 3'd0;
  localparam logic [2:0] REG_COL_COUNT       = 3'd1;
  localparam logic [2:0] REG_REGION_LIMIT    = 3'd2;
  localparam logic [2:0] REG_CAUSAL_MASK     = 3'd3;
  localparam logic [2:0] REG_DERIVATIVE_MODE = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // element store geometry
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;

  // divider sizing: quotient bits and step counter
  localparam int QUOT_W = 26;
  localparam int DIVD_W = QUOT_W - 1;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] FWD_STEPS  = 5'd16;
  localparam logic [STEP_W-1:0] DRV1_STEPS = 5'd24;
  localparam logic [STEP_W-1:0] DRV2_STEPS = 5'd25;

  // fixed point one in Q15.16
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // divider control
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

### rtl/core/msmn_in_if.sv
// input word channel
interface msmn_in_if #(parameter int IN_WIDTH = 16);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

### rtl/core/msmn_out_if.sv
// result word channel
interface msmn_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_value;
  logic [2:0]        row_index;
  logic [2:0]        col_index;
  logic              last_flag;
  logic              empty_flag;

  modport source (output valid, output result_value, output row_index, output col_index,
                  output last_flag, output empty_flag, input ready);
  modport sink (input valid, input result_value, input row_index, input col_index,
                input last_flag, input empty_flag, output ready);
endinterface

### rtl/core/msmn_div.sv
// iterative restoring divider, one quotient bit per cycle
module msmn_div
  import msmn_pkg::*;
#(
  parameter int SW = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [SW-1:0]     rem_init,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [SW-1:0]     divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic              busy;
  logic              first;
  logic [STEP_W-1:0] cnt;
  logic [SW-1:0]     rem;
  logic [SW-1:0]     dsr;
  logic [DIVD_W-1:0] dq;
  logic [SW:0]       cand;
  logic              ge;
  logic [SW:0]       diff;

  // compare step uses the remainder as is, later steps shift in a dividend bit
  always_comb begin
    cand = first ? {1'b0, rem} : {rem, dq[DIVD_W-1]};
    ge   = cand >= {1'b0, dsr};
    diff = cand - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= ctl.steps;
      end else if (busy) begin
        first <= 1'b0;
        if (!first) begin
          cnt <= cnt - 1'b1;
          if (cnt == STEP_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= rem_init;
      dsr  <= divisor;
      dq   <= dividend;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[SW-1:0] : cand[SW-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
      if (!first) begin
        dq <= {dq[DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/core/masked_shift_min_normalizer_unit.sv
// masked shift-min normalizer top level: element store, sequencer, shared divider
// load: one word per cycle; the word that completes the matrix starts processing
// processing: a minimum pass, then a sum pass over the region (skipped at limit one),
//   then per element a read, a calculation, the divider in the region, and the output
// not ready while processing; output word held until taken
// reset: registers 8,8,8,0,0, load count zero; the store is not cleared
module masked_shift_min_normalizer_unit
  import msmn_pkg::*;
#(
  parameter int ROW_CAP  = 8,
  parameter int MAX_COLS = 8,
  parameter int IN_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msmn_in_if.sink               in_ch,
  msmn_out_if.source            out_ch
);

  localparam int SW  = IN_WIDTH + 6;
  localparam int IW1 = IN_WIDTH + 1;

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_SCAN_RD   = 3'd1;
  localparam logic [2:0] S_SCAN_USE  = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_CALC = 3'd4;
  localparam logic [2:0] S_DIV       = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  // configuration registers
  logic [3:0] row_count, col_count, region_limit;
  logic       causal_mask, derivative_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= 4'd8;
      col_count       <= 4'd8;
      region_limit    <= 4'd8;
      causal_mask     <= 1'b0;
      derivative_mode <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ROW_COUNT:       row_count       <= cfg_data;
        REG_COL_COUNT:       col_count       <= cfg_data;
        REG_REGION_LIMIT:    region_limit    <= cfg_data;
        REG_CAUSAL_MASK:     causal_mask     <= cfg_data[0];
        REG_DERIVATIVE_MODE: derivative_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [3:0] rows, cols, nr, cb;
  logic [6:0] total;
  logic [2:0] r, c;
  logic [ADDR_W-1:0] base;

  always_comb begin
    rows  = (row_count == 4'd0) ? 4'd1 :
            (row_count > 4'(ROW_CAP)) ? 4'(ROW_CAP) : row_count;
    cols  = (col_count == 4'd0) ? 4'd1 :
            (col_count > 4'(MAX_COLS)) ? 4'(MAX_COLS) : col_count;
    total = 7'(rows * cols);
    nr    = (region_limit < rows) ? region_limit : rows;
    cb    = causal_mask ? ({1'b0, r} + 4'd1) : region_limit;
    if (cb > cols) begin
      cb = cols;
    end
  end

  // sequencer registers
  logic [2:0]          state;
  logic                pass;
  logic                stage;
  logic [6:0]          load_cnt;
  logic signed [IN_WIDTH-1:0] mn;
  logic [SW-1:0]       sum;
  logic [6:0]          count;
  logic signed [31:0]  res;
  logic [2:0]          res_row, res_col;
  logic                res_last, res_empty;

  // element store
  logic [IN_WIDTH-1:0] store [STORE_DEPTH];
  logic [IN_WIDTH-1:0] rdata;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                in_acc, out_acc;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign rd_en   = (state == S_SCAN_RD) || (state == S_EMIT_RD);
  assign rd_addr = base + ADDR_W'(c);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[load_cnt[ADDR_W-1:0]] <= in_ch.element_value;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // per element arithmetic
  logic signed [IN_WIDTH-1:0] v;
  logic signed [IW1-1:0]      absmin, tv;
  logic [SW-1:0]              t_u;
  logic signed [40:0]         pw;
  logic signed [31:0]         passv;
  logic                       rel_row, in_reg, row_end, col_end;

  always_comb begin
    v       = rdata;
    absmin  = mn[IN_WIDTH-1] ? -IW1'(mn) : IW1'(mn);
    tv      = IW1'(v) + absmin;
    t_u     = SW'(tv[IN_WIDTH-1:0]);
    pw      = 41'(v) <<< 8;
    if (pw > 41'sd2147483647) begin
      passv = 32'sh7fff_ffff;
    end else if (pw < -41'sd2147483648) begin
      passv = 32'sh8000_0000;
    end else begin
      passv = pw[31:0];
    end
    rel_row = {1'b0, r} < nr;
    in_reg  = rel_row && ({1'b0, c} < cb);
    row_end = ({1'b0, r} + 4'd1) >= nr;
    col_end = ({1'b0, c} + 4'd1) >= cb;
  end

  // shared divider
  div_ctl_t          div_ctl;
  logic [SW-1:0]     div_rem, div_dsr;
  logic [DIVD_W-1:0] div_dvd;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  msmn_div #(.SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      load_cnt      <= '0;
      div_ctl.start <= 1'b0;
      div_ctl.steps <= '0;
      pass          <= 1'b0;
      stage         <= 1'b0;
      r             <= '0;
      c             <= '0;
      base          <= '0;
      mn            <= {1'b0, {(IN_WIDTH-1){1'b1}}};
      sum           <= '0;
      count         <= '0;
    end else begin
      div_ctl.start <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            r    <= '0;
            c    <= '0;
            base <= '0;
            if ((load_cnt + 7'd1) >= total) begin
              load_cnt <= '0;
              if (region_limit == 4'd0) begin
                res       <= '0;
                res_row   <= '0;
                res_col   <= '0;
                res_last  <= 1'b1;
                res_empty <= 1'b1;
                state     <= S_OUT;
              end else if (region_limit == 4'd1) begin
                state <= S_EMIT_RD;
              end else begin
                pass  <= 1'b0;
                mn    <= {1'b0, {(IN_WIDTH-1){1'b1}}};
                state <= S_SCAN_RD;
              end
            end else begin
              load_cnt <= load_cnt + 7'd1;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_USE;
        S_SCAN_USE: begin
          if (!pass) begin
            if (v < mn) begin
              mn <= v;
            end
          end else begin
            sum   <= sum + t_u;
            count <= count + 7'd1;
          end
          state <= S_SCAN_RD;
          if (!col_end) begin
            c <= c + 3'd1;
          end else begin
            c    <= '0;
            r    <= r + 3'd1;
            base <= base + ADDR_W'(cols);
            if (row_end) begin
              r    <= '0;
              base <= '0;
              if (!pass) begin
                pass  <= 1'b1;
                sum   <= '0;
                count <= '0;
              end else begin
                state <= S_EMIT_RD;
              end
            end
          end
        end
        S_EMIT_RD: state <= S_EMIT_CALC;
        S_EMIT_CALC: begin
          res_row   <= r;
          res_col   <= c;
          res_last  <= ({1'b0, r} == rows - 4'd1) && ({1'b0, c} == cols - 4'd1);
          res_empty <= 1'b0;
          state     <= S_OUT;
          if (region_limit == 4'd1) begin
            if (r == 3'd0 && c == 3'd0) begin
              res <= derivative_mode ? 32'sd0 : ONE_Q16;
            end else begin
              res <= passv;
            end
          end else if (in_reg) begin
            if (derivative_mode) begin
              if (sum == '0) begin
                res <= '0;
              end else begin
                div_rem       <= sum - t_u;
                div_dsr       <= sum;
                div_dvd       <= '0;
                div_ctl.steps <= DRV1_STEPS;
                div_ctl.start <= 1'b1;
                stage         <= 1'b0;
                state         <= S_DIV;
              end
            end else begin
              div_rem       <= (sum == '0) ? SW'(1) : t_u;
              div_dsr       <= (sum == '0) ? SW'(count) : sum;
              div_dvd       <= '0;
              div_ctl.steps <= FWD_STEPS;
              div_ctl.start <= 1'b1;
              stage         <= 1'b1;
              state         <= S_DIV;
            end
          end else if (rel_row && causal_mask) begin
            res <= '0;
          end else begin
            res <= passv;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!stage) begin
              // second pass divides the scaled quotient by the sum again
              div_rem       <= '0;
              div_dvd       <= div_quot[DIVD_W-1:0];
              div_ctl.steps <= DRV2_STEPS;
              div_ctl.start <= 1'b1;
              stage         <= 1'b1;
            end else begin
              res   <= 32'(div_quot);
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (res_last) begin
              state <= S_LOAD;
            end else begin
              state <= S_EMIT_RD;
              if (({1'b0, c} + 4'd1) >= cols) begin
                c    <= '0;
                r    <= r + 3'd1;
                base <= base + ADDR_W'(cols);
              end else begin
                c <= c + 3'd1;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // channel ports
  assign in_ch.ready         = (state == S_LOAD);
  assign out_ch.valid        = (state == S_OUT);
  assign out_ch.result_value = res;
  assign out_ch.row_index    = res_row;
  assign out_ch.col_index    = res_col;
  assign out_ch.last_flag    = res_last;
  assign out_ch.empty_flag   = res_empty;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("load and output active together");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.last_flag) |=> in_ch.ready)
    else $error("no return to load after last word");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.empty_flag) |-> (out_ch.last_flag && out_ch.result_value == 0))
    else $error("empty word malformed");

endmodule

### tb/tb_masked_shift_min_normalizer_unit.sv
// self-checking testbench for the masked shift-min normalizer unit
`timescale 1ns / 1ps

module tb_masked_shift_min_normalizer_unit;
  import msmn_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         row;
    logic [2:0]         col;
    logic               last;
    logic               empty;
  } norm_word_t;

  // predicts the normalized matrix and checks emitted words against it
  class norm_scoreboard;
    logic signed [15:0] elem_store [STORE_DEPTH];
    int unsigned        load_cnt;
    int unsigned        rows_reg, cols_reg, limit_reg;
    bit                 causal_reg, deriv_reg;
    norm_word_t         expected_q [$];
    int                 errors;

    function new();
      load_cnt = 0;
      rows_reg = 8; cols_reg = 8; limit_reg = 8;
      causal_reg = 0; deriv_reg = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROW_COUNT:       rows_reg = val;
        REG_COL_COUNT:       cols_reg = val;
        REG_REGION_LIMIT:    limit_reg = val;
        REG_CAUSAL_MASK:     causal_reg = val[0];
        REG_DERIVATIVE_MODE: deriv_reg = val[0];
        default: ;
      endcase
    endfunction

    // zero acts as one, above the maximum acts as the maximum
    function int unsigned clip_count(int unsigned v);
      return (v == 0) ? 1 : ((v > 8) ? 8 : v);
    endfunction

    function int unsigned col_bound(int unsigned r, int unsigned cols);
      int unsigned b;
      b = causal_reg ? r + 1 : limit_reg;
      return (b < cols) ? b : cols;
    endfunction

    function void note_input(logic signed [15:0] v);
      int unsigned rows, cols, nr, cnt;
      longint      mn, absmin, sum, vv, t, res;
      norm_word_t  w;
      rows = clip_count(rows_reg);
      cols = clip_count(cols_reg);
      elem_store[load_cnt % STORE_DEPTH] = v;
      load_cnt++;
      if (load_cnt < rows * cols) return;
      load_cnt = 0;
      // empty region gives one flagged word
      if (limit_reg == 0) begin
        w = '{value: 0, row: 0, col: 0, last: 1, empty: 1};
        expected_q.push_back(w);
        return;
      end
      nr = (limit_reg < rows) ? limit_reg : rows;
      mn = 32767;
      sum = 0;
      cnt = 0;
      for (int unsigned r = 0; r < nr; r++)
        for (int unsigned c = 0; c < col_bound(r, cols); c++)
          if (elem_store[(r * cols + c) % STORE_DEPTH] < mn)
            mn = elem_store[(r * cols + c) % STORE_DEPTH];
      absmin = (mn < 0) ? -mn : mn;
      for (int unsigned r = 0; r < nr; r++)
        for (int unsigned c = 0; c < col_bound(r, cols); c++) begin
          sum += longint'(elem_store[(r * cols + c) % STORE_DEPTH]) + absmin;
          cnt++;
        end
      // emit every element row-major
      for (int unsigned r = 0; r < rows; r++)
        for (int unsigned c = 0; c < cols; c++) begin
          vv = elem_store[(r * cols + c) % STORE_DEPTH];
          if (limit_reg == 1) begin
            if (r == 0 && c == 0) res = deriv_reg ? 0 : 65536;
            else res = vv * 256;
          end else if (r < nr && c < col_bound(r, cols)) begin
            t = vv + absmin;
            if (!deriv_reg) res = (sum > 0) ? (t << 16) / sum : 65536 / cnt;
            else res = (sum > 0) ? (((sum - t) << 24) / sum) / sum : 0;
          end else if (r < nr && causal_reg) begin
            res = 0;
          end else begin
            res = vv * 256;
          end
          if (res > 64'sd2147483647) res = 64'sd2147483647;
          if (res < -64'sd2147483648) res = -64'sd2147483648;
          w.value = res[31:0];
          w.row   = r[2:0];
          w.col   = c[2:0];
          w.last  = (r == rows - 1 && c == cols - 1);
          w.empty = 0;
          expected_q.push_back(w);
        end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(norm_word_t got);
      norm_word_t exp_w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d row %0d col %0d",
                                  got.value, got.row, got.col));
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.value !== exp_w.value || got.row !== exp_w.row || got.col !== exp_w.col ||
          got.last !== exp_w.last || got.empty !== exp_w.empty)
        report_mismatch($sformatf("got %0d r%0d c%0d l%0b e%0b, want %0d r%0d c%0d l%0b e%0b",
                                  got.value, got.row, got.col, got.last, got.empty,
                                  exp_w.value, exp_w.row, exp_w.col, exp_w.last,
                                  exp_w.empty));
    endtask
  endclass

  logic clk;
  logic rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msmn_in_if #(.IN_WIDTH(16)) in_ch ();
  msmn_out_if                 out_ch ();

  masked_shift_min_normalizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  norm_scoreboard sb = new();
  int unsigned    words_sent;
  bit             calm;
  bit             hold_req;
  int unsigned    hold_cnt;
  int unsigned    quiet_cycles;

  // clock
  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{value: out_ch.result_value, row: out_ch.row_index,
                          col: out_ch.col_index, last: out_ch.last_flag,
                          empty: out_ch.empty_flag});
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 300;
      end
      if (rst) out_ch.ready <= 0;
      else if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 0;
      end else out_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  task send_word(logic signed [15:0] v);
    if (!calm && $urandom_range(99) < 7) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1;
    in_ch.element_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(v);
    words_sent++;
  endtask

  // wait for every expected word, then let the block settle
  task drain();
    in_ch.valid <= 0;
    @(posedge clk);
    wait (sb.expected_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task configure(int unsigned rows, int unsigned cols, int unsigned lim, bit causal, bit deriv);
    logic [CFG_DATA_W-1:0] vals [5];
    vals = '{rows[3:0], cols[3:0], lim[3:0], {3'b0, causal}, {3'b0, deriv}};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_write_en <= 1;
      cfg_index    <= i[CFG_IDX_W-1:0];
      cfg_data     <= vals[i];
      @(posedge clk);
      sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    cfg_write_en <= 0;
  endtask

  function logic signed [15:0] pick_value(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(511)) - 256);
      2: return 16'sd0;
      default: return 16'($urandom_range(2000));
    endcase
  endfunction

  initial begin
    int unsigned rows, cols, lim, style, n_mat, phase;
    rst          <= 1;
    cfg_write_en <= 0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 0;
    in_ch.element_value <= '0;
    calm = 0;
    hold_req = 0;
    words_sent = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // extremes with a negative minimum, forward
    configure(2, 2, 2, 0, 0);
    send_word(16'sh7fff); send_word(-16'sd32768); send_word(0); send_word(1);
    // derivative with zero sum
    configure(2, 2, 2, 0, 1);
    repeat (4) send_word(0);
    // forward with zero sum
    configure(1, 2, 2, 0, 0);
    repeat (2) send_word(0);
    // empty region
    configure(1, 1, 0, 0, 0);
    send_word(16'sh1234);
    // limit one, forward and derivative
    configure(1, 2, 1, 1, 0);
    send_word(-16'sd5); send_word(16'sd300);
    configure(1, 1, 1, 0, 1);
    send_word(16'sd77);
    // causal masking
    configure(2, 2, 2, 1, 0);
    send_word(16'sd10); send_word(16'sd20); send_word(-16'sd3); send_word(16'sd40);
    // counts out of range: zero rows, oversized columns and limit
    configure(0, 15, 15, 0, 1);
    repeat (8) send_word(16'($urandom));
    // column count shrinks in the middle of a load
    configure(1, 2, 2, 0, 0);
    send_word(16'sd100);
    configure(1, 1, 2, 0, 0);
    send_word(16'sd200);

    // random phases
    phase = 0;
    while (words_sent < 200) begin
      calm = (phase >= 5 && phase <= 8);
      rows = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
      cols = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
      lim  = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(0, 5);
      if (phase == 3) begin
        rows = 8; cols = 8; lim = 8;
      end
      configure(rows, cols, lim, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (phase == 3) hold_req = 1;
      n_mat = (phase == 3) ? 1 : $urandom_range(1, 3);
      for (int m = 0; m < n_mat; m++) begin
        style = $urandom_range(5);
        for (int k = 0; k < sb.clip_count(rows) * sb.clip_count(cols); k++)
          send_word(pick_value(style));
      end
      phase++;
    end
    drain();
    calm = 0;

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
